// ----- hdl/bzpt_pkg.sv -----
// ----------------------------------------------------------------------------
// Bezier evaluator package
// Shared constants and types for the point and tangent evaluator.
// ----------------------------------------------------------------------------
package bzpt_pkg;

    localparam int T_BITS     = 16;
    localparam int FRAC_BITS  = 15;
    localparam int ONE_Q15    = 32768;
    localparam int COORD_BITS = 16;
    localparam int PT_BITS    = 16;
    localparam int TG_BITS    = 19;
    localparam int REG_BITS   = 3 * COORD_BITS;
    localparam int IDX_BITS   = 3;

    localparam logic [IDX_BITS-1:0] REG_DEGREE = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_CP0    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_CP1    = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_CP2    = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_CP3    = 3'd4;

    typedef logic [FRAC_BITS:0] t_q15;

endpackage

// ----- hdl/bzpt_lerp_cell.sv -----
// ----------------------------------------------------------------------------
// Bezier lerp cell
// One de Casteljau step on one coordinate, registered; t is an input per cell.
// ----------------------------------------------------------------------------
module bzpt_lerp_cell
    import bzpt_pkg::*;
#(
    parameter int W = 40
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  bzpt_pkg::t_q15      i_t,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic signed [W+FRAC_BITS-1:0] o_q
);
    // o_q = a*(1-t) + b*t = a*2^15 + (b-a)*t, scaled by 2^15.
    logic signed [W:0]                 w_d;
    logic signed [W+FRAC_BITS+1:0]     w_m;
    logic signed [W+FRAC_BITS+1:0]     w_p;
    logic signed [W+FRAC_BITS-1:0]     r_q;

    assign w_d = {i_b[W-1], i_b} - {i_a[W-1], i_a};
    assign w_m = w_d * $signed({1'b0, i_t});
    assign w_p = w_m + ((W+FRAC_BITS+2)'(i_a) <<< FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= w_p[W+FRAC_BITS-1:0];
        end
    end

    assign o_q = r_q;
endmodule

// ----- hdl/bzpt_axis.sv -----
// ----------------------------------------------------------------------------
// Bezier axis chain
// Three rows of lerp cells evaluating one coordinate and its tangent.
// ----------------------------------------------------------------------------
module bzpt_axis
    import bzpt_pkg::*;
#(
    parameter int CB = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_cubic,
    input  bzpt_pkg::t_q15       i_t0,
    input  bzpt_pkg::t_q15       i_t1,
    input  bzpt_pkg::t_q15       i_t2,
    input  logic signed [CB-1:0] i_p0,
    input  logic signed [CB-1:0] i_p1,
    input  logic signed [CB-1:0] i_p2,
    input  logic signed [CB-1:0] i_p3,
    output logic signed [PT_BITS-1:0] o_pt,
    output logic signed [TG_BITS-1:0] o_tg
);
    localparam int W1 = CB + FRAC_BITS;
    localparam int W2 = W1 + FRAC_BITS;
    localparam int W3 = W2 + FRAC_BITS;

    logic signed [W1-1:0] w_a0, w_a1, w_a2;
    logic signed [W2-1:0] w_b0, w_b1;
    logic signed [W3-1:0] w_c0;
    logic signed [CB-1:0] w_p3;
    logic signed [W2-1:0] r_quad_pt;
    logic signed [W2+2:0] w_td;
    logic signed [W3-1:0] w_pr;
    logic signed [W2+2:0] w_tr;
    logic signed [W3:0]   w_pre;
    logic signed [W2+2:0] w_tre;

    assign w_p3 = i_cubic ? i_p3 : i_p2;

    bzpt_lerp_cell #(.W(CB)) u_a0 (.i_clk, .i_en, .i_t(i_t0), .i_a(i_p0), .i_b(i_p1), .o_q(w_a0));
    bzpt_lerp_cell #(.W(CB)) u_a1 (.i_clk, .i_en, .i_t(i_t0), .i_a(i_p1), .i_b(i_p2), .o_q(w_a1));
    bzpt_lerp_cell #(.W(CB)) u_a2 (.i_clk, .i_en, .i_t(i_t0), .i_a(i_p2), .i_b(w_p3), .o_q(w_a2));
    bzpt_lerp_cell #(.W(W1)) u_b0 (.i_clk, .i_en, .i_t(i_t1), .i_a(w_a0), .i_b(w_a1), .o_q(w_b0));
    bzpt_lerp_cell #(.W(W1)) u_b1 (.i_clk, .i_en, .i_t(i_t1), .i_a(w_a1), .i_b(w_a2), .o_q(w_b1));
    bzpt_lerp_cell #(.W(W2)) u_c0 (.i_clk, .i_en, .i_t(i_t2), .i_a(w_b0), .i_b(w_b1), .o_q(w_c0));

    // Quadratic: point is b0 (scale 2^30), held to align with c0.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quad_pt <= w_b0;
        end
    end

    // Cubic derivative: 3*(b1-b0) at scale 2^30; quadratic: 2*(a1-a0) at 2^15,
    // held two stages to align with c0.
    logic signed [W1+1:0] r_qd1, r_qd2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qd1 <= (W1+2)'(w_a1) - (W1+2)'(w_a0);
            r_qd2 <= r_qd1;
        end
    end
    logic signed [W2+1:0] r_cd;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cd <= (W2+2)'(w_b1) - (W2+2)'(w_b0);
        end
    end

    assign w_td = i_cubic ? ((W2+3)'(r_cd) + ((W2+3)'(r_cd) <<< 1))
                          : ((W2+3)'(r_qd2) <<< 1);
    assign w_pr = i_cubic ? w_c0 : (W3'(r_quad_pt) <<< FRAC_BITS);
    assign w_tr = i_cubic ? w_td : (w_td <<< FRAC_BITS);

    assign w_pre = (W3+1)'(w_pr) + ((W3+1)'(1) <<< (3*FRAC_BITS-1));
    assign w_tre = w_tr + ((W2+3)'(1) <<< (2*FRAC_BITS-1));
    assign o_pt = PT_BITS'(w_pre >>> (3*FRAC_BITS));
    assign o_tg = TG_BITS'(w_tre >>> (2*FRAC_BITS));
endmodule

// ----- hdl/bezier_point_tangent_eval.sv -----
// Pipeline: three cell rows, each with a valid flag that moves along with the
// data; the last flag drives output valid.
// Throughput: one parameter per cycle; the whole chain advances when the
// output register is empty or being taken.
// Reset: synchronous active low; degree resets to cubic, control points to 0,
// and all valid flags clear.
// ----------------------------------------------------------------------------
// Bezier point and tangent evaluator
// Evaluates a quadratic or cubic 3D Bezier curve point and tangent at t.
// ----------------------------------------------------------------------------
module bezier_point_tangent_eval
    import bzpt_pkg::*;
#(
    parameter int MAX_DEGREE = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [IDX_BITS-1:0]   i_cfg_idx,
    input  logic [REG_BITS-1:0]   i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [T_BITS-1:0]     i_param_t,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [PT_BITS-1:0] o_point_x,
    output logic signed [PT_BITS-1:0] o_point_y,
    output logic signed [PT_BITS-1:0] o_point_z,
    output logic signed [TG_BITS-1:0] o_tangent_x,
    output logic signed [TG_BITS-1:0] o_tangent_y,
    output logic signed [TG_BITS-1:0] o_tangent_z
);
    localparam int CB = COORD_BITS;

    logic [1:0]          r_deg;
    logic [REG_BITS-1:0] r_cp [4];
    logic                w_cubic;
    logic [2:0]          r_v;
    t_q15                r_t1, r_t2, w_t0;
    logic                w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= 2'd3;
            for (int k = 0; k < 4; k++) r_cp[k] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEGREE: r_deg    <= i_cfg_data[1:0];
                REG_CP0:    r_cp[0]  <= i_cfg_data;
                REG_CP1:    r_cp[1]  <= i_cfg_data;
                REG_CP2:    r_cp[2]  <= i_cfg_data;
                REG_CP3:    r_cp[3]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb w_cubic = (MAX_DEGREE >= 3) && (r_deg == 2'd3);

    assign w_en    = !r_v[2] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v[2];
    assign w_t0    = (i_param_t > T_BITS'(ONE_Q15)) ? t_q15'(ONE_Q15) : t_q15'(i_param_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1 <= w_t0;
            r_t2 <= r_t1;
        end
    end

    logic signed [PT_BITS-1:0] w_pt [3];
    logic signed [TG_BITS-1:0] w_tg [3];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        bzpt_axis #(.CB(CB)) u_axis (
            .i_clk, .i_en(w_en), .i_cubic(w_cubic),
            .i_t0(w_t0), .i_t1(r_t1), .i_t2(r_t2),
            .i_p0(r_cp[0][a*CB +: CB]), .i_p1(r_cp[1][a*CB +: CB]),
            .i_p2(r_cp[2][a*CB +: CB]), .i_p3(r_cp[3][a*CB +: CB]),
            .o_pt(w_pt[a]), .o_tg(w_tg[a])
        );
    end

    assign o_point_x   = w_pt[0];
    assign o_point_y   = w_pt[1];
    assign o_point_z   = w_pt[2];
    assign o_tangent_x = w_tg[0];
    assign o_tangent_y = w_tg[1];
    assign o_tangent_z = w_tg[2];
endmodule

// ----- dv/tb_bezier_point_tangent_eval.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bezier evaluator testbench
// Drives curve parameters through the evaluator under several degree and
// control point settings and checks every point and tangent against an
// internal exact integer predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_bezier_point_tangent_eval;
    import bzpt_pkg::*;

    typedef struct {
        logic signed [PT_BITS-1:0] pt[3];
        logic signed [TG_BITS-1:0] tg[3];
    } t_curve_sample;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [IDX_BITS-1:0] i_cfg_idx = REG_DEGREE;
    logic [REG_BITS-1:0] i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [T_BITS-1:0]   i_param_t = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic signed [PT_BITS-1:0] o_point_x, o_point_y, o_point_z;
    logic signed [TG_BITS-1:0] o_tangent_x, o_tangent_y, o_tangent_z;

    logic [1:0]          degree_reg = 2'd3;
    logic [REG_BITS-1:0] ctrl_reg[4] = '{default: '0};

    logic [T_BITS-1:0]   param_queue[$];
    t_curve_sample       sample_queue[$];
    int                  sent_count = 0;
    int                  send_idle_pct = 8;
    int                  recv_idle_pct = 50;
    bit                  failed = 1'b0;

    bezier_point_tangent_eval dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint bern_weight(int n, int i, longint u, longint t);
        longint w;
        w = ((n == 3 && (i == 1 || i == 2)) ? 3 : (n == 2 && i == 1) ? 2 : 1);
        for (int k = 0; k < n - i; k++) w = w * u;
        for (int k = 0; k < i; k++) w = w * t;
        return w;
    endfunction

    function automatic longint round_nearest(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint coord(int i, int a);
        return longint'($signed(ctrl_reg[i][16*a +: 16]));
    endfunction

    function automatic t_curve_sample eval_curve(logic [T_BITS-1:0] t_in);
        t_curve_sample r;
        longint tt, uu, acc;
        int n;
        n = (degree_reg < 2) ? 2 : int'(degree_reg);
        tt = (t_in > ONE_Q15) ? longint'(ONE_Q15) : longint'(t_in);
        uu = ONE_Q15 - tt;
        for (int a = 0; a < 3; a++) begin
            acc = 0;
            for (int i = 0; i <= n; i++) acc += bern_weight(n, i, uu, tt) * coord(i, a);
            r.pt[a] = PT_BITS'(round_nearest(acc, FRAC_BITS * n));
            acc = 0;
            for (int i = 0; i < n; i++)
                acc += bern_weight(n - 1, i, uu, tt) * (coord(i + 1, a) - coord(i, a));
            r.tg[a] = TG_BITS'(round_nearest(acc * n, FRAC_BITS * (n - 1)));
        end
        return r;
    endfunction

    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [REG_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == REG_DEGREE) degree_reg = data[1:0];
        else if (idx <= REG_CP3) ctrl_reg[idx - 1] = data;
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (param_queue.size() != 0 || sample_queue.size() != 0 || i_valid);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [REG_BITS-1:0] rand_point();
        logic [REG_BITS-1:0] p;
        p = REG_BITS'({$urandom, $urandom});
        for (int a = 0; a < 3; a++)
            if ($urandom_range(9) == 0) p[16*a +: 16] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        return p;
    endfunction

    function automatic logic [T_BITS-1:0] rand_param();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return T_BITS'($urandom_range(ONE_Q15));
        if (sel < 80) return $urandom_range(1) ? T_BITS'(ONE_Q15) : T_BITS'(0);
        return T_BITS'($urandom);
    endfunction

    // Sender side: holds valid until the transfer, predicts at acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                sample_queue.push_back(eval_curve(i_param_t));
                sent_count++;
            end
            if (!i_valid || o_ready) begin
                if (param_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid   <= 1'b1;
                    i_param_t <= param_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (sent_count < 330) begin
            send_idle_pct <= 8;
            recv_idle_pct <= 50;
        end else if (sent_count < 660) begin
            send_idle_pct <= 50;
            recv_idle_pct <= 8;
        end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end
    end

    // Receiver side: random backpressure and field by field comparison.
    always @(posedge i_clk) begin
        t_curve_sample want;
        logic signed [PT_BITS-1:0] got_pt[3];
        logic signed [TG_BITS-1:0] got_tg[3];
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (o_valid && i_ready) begin
                got_pt = '{o_point_x, o_point_y, o_point_z};
                got_tg = '{o_tangent_x, o_tangent_y, o_tangent_z};
                if (sample_queue.size() == 0) begin
                    $display("%0t: unexpected output transfer", $time);
                    failed = 1'b1;
                end else begin
                    want = sample_queue.pop_front();
                    for (int a = 0; a < 3; a++) begin
                        if (got_pt[a] !== want.pt[a]) begin
                            $display("%0t: point[%0d] expected %0d actual %0d",
                                     $time, a, want.pt[a], got_pt[a]);
                            failed = 1'b1;
                        end
                        if (got_tg[a] !== want.tg[a]) begin
                            $display("%0t: tangent[%0d] expected %0d actual %0d",
                                     $time, a, want.tg[a], got_tg[a]);
                            failed = 1'b1;
                        end
                    end
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [T_BITS-1:0] edge_params[7] = '{0, 1, 16384, 32767, 32768, 32769, 65535};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        param_queue.push_back(0);
        param_queue.push_back(ONE_Q15);
        wait_drained();

        write_reg(REG_DEGREE, 48'd3);
        write_reg(REG_CP0, 48'h8000_8000_8000);
        write_reg(REG_CP1, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_CP2, 48'h8000_8000_8000);
        write_reg(REG_CP3, 48'h7FFF_7FFF_7FFF);
        write_reg(3'd5, 48'h1234_5678_9ABC);
        write_reg(3'd6, '1);
        write_reg(3'd7, '1);
        end_writes();
        foreach (edge_params[k]) param_queue.push_back(edge_params[k]);
        wait_drained();

        write_reg(REG_DEGREE, 48'hFFFF_FFFF_FFF2);
        write_reg(REG_CP3, 48'h1111_2222_3333);
        end_writes();
        foreach (edge_params[k]) param_queue.push_back(edge_params[k]);
        wait_drained();

        for (int d = 0; d < 2; d++) begin
            write_reg(REG_DEGREE, REG_BITS'(d));
            write_reg(REG_CP1, rand_point());
            end_writes();
            param_queue.push_back(16384);
            param_queue.push_back(rand_param());
            param_queue.push_back(ONE_Q15);
            wait_drained();
        end

        for (int ph = 0; ph < 12; ph++) begin
            write_reg(REG_DEGREE, REG_BITS'({$urandom, $urandom}));
            for (int i = 0; i < 4; i++) begin
                if (ph == 3)
                    write_reg(IDX_BITS'(REG_CP0 + i),
                              i[0] ? 48'h7FFF_7FFF_7FFF : 48'h8000_8000_8000);
                else if (ph == 7)
                    write_reg(IDX_BITS'(REG_CP0 + i),
                              i[0] ? 48'h8000_8000_8000 : 48'h7FFF_7FFF_7FFF);
                else write_reg(IDX_BITS'(REG_CP0 + i), rand_point());
            end
            if ($urandom_range(2) == 0)
                write_reg(IDX_BITS'($urandom_range(7, 5)), REG_BITS'({$urandom, $urandom}));
            end_writes();
            for (int k = 0; k < 80; k++) param_queue.push_back(rand_param());
            wait_drained();
        end

        if (failed) begin
            $display("RESULT: ERROR");
        end else begin
            $display("RESULT: OK");
        end
        $finish;
    end

endmodule
